/* src/hpns_pkg.sv */
package hpns_pkg;

  // Chunk geometry
  localparam int unsigned CHUNK_COLS  = 16;
  localparam int unsigned CHUNK_ROWS  = 16;
  localparam int unsigned TILE_PIXELS = 8;

  // Hash datapath
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned HASH_FOLD = 16;
  localparam logic [HASH_W-1:0] HASH_MUL_X   = 32'd1619;
  localparam logic [HASH_W-1:0] HASH_MUL_Y   = 32'd31337;
  localparam logic [HASH_W-1:0] HASH_ADD     = 32'd9371;
  localparam logic [HASH_W-1:0] HASH_MUL_MIX = 32'h045d9f3b;

  // Remainder pipeline: hash bits retired per stage, stage count
  localparam int unsigned REM_BITS   = 4;
  localparam int unsigned REM_STAGES = HASH_W / REM_BITS;
  localparam int unsigned REM_W      = 8;

  localparam int unsigned PIX_IDX_W   = 14;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned AMP_W       = 7;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] CH_MAX       = 8'hFF;

  // Config port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [AMP_W-1:0] AMP_RESET = 7'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK_X   = 2'd0,
    REG_CHUNK_Y   = 2'd1,
    REG_NOISE_AMP = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]      tile_row;
    logic [3:0]      tile_col;
    logic [2:0]      sub_row;
    logic [2:0]      sub_col;
    logic [CH_W-1:0] base_red;
    logic [CH_W-1:0] base_green;
    logic [CH_W-1:0] base_blue;
  } pix_word_t;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [31:0]          pixel_word;
  } res_word_t;

  // Fields that ride along the pipeline untouched
  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
  } side_t;

endpackage

/* src/hpns_rem_stage.sv */
module hpns_rem_stage import hpns_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [HASH_W-1:0] hash_in,
  input  logic [REM_BITS-1:0] bits_in,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [REM_W-1:0]  divisor,
  output logic [HASH_W-1:0] hash_out,
  output logic [REM_W-1:0]  rem_out
);

  logic [REM_W-1:0] rem_next;

  // Restoring remainder steps, MSB first; rem < divisor keeps each step to one subtract
  always_comb begin
    logic [REM_W:0]   t;
    logic [REM_W-1:0] r;
    r = rem_in;
    t = '0;
    for (int i = REM_BITS - 1; i >= 0; i--) begin
      t = {r, bits_in[i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[REM_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hash_out <= hash_in;
      rem_out  <= rem_next;
    end
  end

endmodule

/* src/hashed_pixel_noise_shader.sv */
// Channel | Dir | Handshake                     | Contents
// pix     | in  | pix_valid / pix_ready         | pix_word: tile/sub position, base RGB
// res     | out | res_valid / res_ready         | res_word: pixel index, ARGB word
// cfg     | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data (chunk_x, chunk_y, amp)
//
// One word per cycle while res_ready stays high; a word from pix to res passes through
// the hash (3 stages), the 8-stage remainder pipeline
// (4 hash bits per stage) and the saturating output stage.
// rst clears all valid bits and loads the register defaults (amplitude 8).
// Each stage holds while the one after it is full and stalled; empty
// stages fill behind a stall, so pix_ready drops only when all stages are full.
module hashed_pixel_noise_shader import hpns_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  pix_word_t             pix_word,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_word_t             res_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned REM_FIRST = 3;
  localparam int unsigned NST       = REM_FIRST + REM_STAGES + 1;
  localparam int unsigned OUT_ST    = NST - 1;

  logic [CFG_DATA_W-1:0] chunk_x;
  logic [CFG_DATA_W-1:0] chunk_y;
  logic [AMP_W-1:0]      noise_amp;
  logic [REM_W-1:0]      divisor;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;
  side_t          side [OUT_ST];

  logic [HASH_W-1:0] x_pos, y_pos, pix_idx_full;
  logic [HASH_W-1:0] prod_x, prod_y, h_sum, h_fold, h_mix, h_mix_fold;
  logic [HASH_W-1:0] hash_src [REM_STAGES];
  logic [REM_W-1:0]  rem_src  [REM_STAGES];
  logic [HASH_W-1:0] hash_q   [REM_STAGES];
  logic [REM_W-1:0]  rem_q    [REM_STAGES];
  logic signed [REM_W:0] noise;

  // Add signed offset to one channel, clamp to 0..255
  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] ch,
                                               input logic signed [REM_W:0] ofs);
    logic signed [CH_W+1:0] sum;
    sum = $signed({2'b00, ch}) + {ofs[REM_W], ofs};
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({2'b00, CH_MAX})) begin
      return CH_MAX;
    end else begin
      return sum[CH_W-1:0];
    end
  endfunction

  // Config registers, writes taken every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_x   <= '0;
      chunk_y   <= '0;
      noise_amp <= AMP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CHUNK_X:   chunk_x   <= cfg_data;
        REG_CHUNK_Y:   chunk_y   <= cfg_data;
        REG_NOISE_AMP: noise_amp <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign divisor = {noise_amp, 1'b1};

  // Per-stage ready: a stage loads when empty or when its word moves on
  always_comb begin
    rdy[NST] = res_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign pix_ready = rdy[0];
  assign res_valid = v[OUT_ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= pix_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // World coordinates and texture index, 32-bit wrap
  always_comb begin
    x_pos = ({{(HASH_W-CFG_DATA_W){chunk_x[CFG_DATA_W-1]}}, chunk_x} * 32'(CHUNK_COLS)
             + 32'(pix_word.tile_col)) * 32'(TILE_PIXELS) + 32'(pix_word.sub_col);
    y_pos = ({{(HASH_W-CFG_DATA_W){chunk_y[CFG_DATA_W-1]}}, chunk_y} * 32'(CHUNK_ROWS)
             + 32'(pix_word.tile_row)) * 32'(TILE_PIXELS) + 32'(pix_word.sub_row);
    pix_idx_full = (32'(pix_word.tile_row) * 32'(TILE_PIXELS) + 32'(pix_word.sub_row))
                   * 32'(CHUNK_COLS * TILE_PIXELS)
                   + 32'(pix_word.tile_col) * 32'(TILE_PIXELS) + 32'(pix_word.sub_col);
  end

  // Stage 0: coordinate products
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod_x              <= x_pos * HASH_MUL_X;
      prod_y              <= y_pos * HASH_MUL_Y;
      side[0].pixel_index <= pix_idx_full[PIX_IDX_W-1:0];
      side[0].red         <= pix_word.base_red;
      side[0].green       <= pix_word.base_green;
      side[0].blue        <= pix_word.base_blue;
    end
  end

  // Stage 1: sum and first fold
  assign h_sum = prod_x + prod_y + HASH_ADD;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      h_fold  <= h_sum ^ (h_sum >> HASH_FOLD);
      side[1] <= side[0];
    end
  end

  // Stage 2: mix multiply
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      h_mix   <= h_fold * HASH_MUL_MIX;
      side[2] <= side[1];
    end
  end

  assign h_mix_fold = h_mix ^ (h_mix >> HASH_FOLD);

  // Remainder pipeline: hash mod (2*amp+1), REM_BITS hash bits per stage
  for (genvar g = 0; g < REM_STAGES; g++) begin : g_rem
    if (g == 0) begin : g_head
      assign hash_src[g] = h_mix_fold;
      assign rem_src[g]  = '0;
    end else begin : g_body
      assign hash_src[g] = hash_q[g-1];
      assign rem_src[g]  = rem_q[g-1];
    end

    hpns_rem_stage u_rem (
      .clk      (clk),
      .en       (rdy[REM_FIRST+g]),
      .hash_in  (hash_src[g]),
      .bits_in  (hash_src[g][HASH_W-1-g*REM_BITS -: REM_BITS]),
      .rem_in   (rem_src[g]),
      .divisor  (divisor),
      .hash_out (hash_q[g]),
      .rem_out  (rem_q[g])
    );

    always_ff @(posedge clk) begin
      if (rdy[REM_FIRST+g]) begin
        side[REM_FIRST+g] <= side[REM_FIRST+g-1];
      end
    end
  end

  // Output stage: signed offset, saturate, pack ARGB
  assign noise = $signed({1'b0, rem_q[REM_STAGES-1]}) - $signed({2'b00, noise_amp});

  always_ff @(posedge clk) begin
    if (rdy[OUT_ST]) begin
      res_word.pixel_index <= side[OUT_ST-1].pixel_index;
      res_word.pixel_word  <= {ALPHA_OPAQUE,
                               sat_add(side[OUT_ST-1].red, noise),
                               sat_add(side[OUT_ST-1].green, noise),
                               sat_add(side[OUT_ST-1].blue, noise)};
    end
  end

  // Final remainder is always below the modulus
  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    v[OUT_ST-1] |-> rem_q[REM_STAGES-1] < divisor)
    else $error("remainder not below modulus");

  // A stalled remainder stage keeps its word
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    v[REM_FIRST] && !rdy[REM_FIRST+1] |=> v[REM_FIRST])
    else $error("stalled stage dropped its word");

  // Input blocks only when every stage is occupied
  a_block_only_full: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> &v)
    else $error("input blocked with an empty stage");

endmodule

/* sim/hpns_shade_checker.sv */
module hpns_shade_checker import hpns_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  input  logic                  pix_ready,
  input  pix_word_t             pix_word,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  res_word_t             res_word,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    bad_words,
  output int                    pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the block's registers
  logic [15:0]      chunk_x_pos;
  logic [15:0]      chunk_y_pos;
  logic [AMP_W-1:0] noise_amp;

  res_word_t shaded_q[$];
  res_word_t want;
  int        miss_count;

  // Add a signed offset to one channel, clamped to 0..255
  function automatic logic [7:0] brighten(logic [7:0] level, int offset);
    int v;
    v = level;
    v = v + offset;
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Expected result word for one pixel under the current register values
  function automatic res_word_t shade_pixel(pix_word_t p);
    logic [31:0] wx, wy, h, span, rem, idx;
    int          offset, rem_i, amp_i;
    res_word_t   r;
    // world coordinates, 32-bit wraparound
    wx = {{16{chunk_x_pos[15]}}, chunk_x_pos};
    wy = {{16{chunk_y_pos[15]}}, chunk_y_pos};
    wx = (wx * CHUNK_COLS + p.tile_col) * TILE_PIXELS + p.sub_col;
    wy = (wy * CHUNK_ROWS + p.tile_row) * TILE_PIXELS + p.sub_row;
    // multiply-xorshift hash
    h = wx * 32'd1619 + wy * 32'd31337 + 32'd9371;
    h = h ^ (h >> 16);
    h = h * 32'h045d9f3b;
    h = h ^ (h >> 16);
    // offset in -amp..+amp
    span   = {24'd0, noise_amp, 1'b1};
    rem    = h % span;
    rem_i  = rem;
    amp_i  = noise_amp;
    offset = rem_i - amp_i;
    idx = (p.tile_row * TILE_PIXELS + p.sub_row) * (CHUNK_COLS * TILE_PIXELS)
        + p.tile_col * TILE_PIXELS + p.sub_col;
    r.pixel_index = idx[PIX_IDX_W-1:0];
    r.pixel_word  = {8'hFF, brighten(p.base_red, offset), brighten(p.base_green, offset),
                     brighten(p.base_blue, offset)};
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shaded_q.delete();
      chunk_x_pos = '0;
      chunk_y_pos = '0;
      noise_amp   = 7'd8;
    end else begin
      // register writes; spare index is dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHUNK_X:   chunk_x_pos = cfg_data;
          REG_CHUNK_Y:   chunk_y_pos = cfg_data;
          REG_NOISE_AMP: noise_amp   = cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      if (pix_valid && pix_ready) shaded_q.push_back(shade_pixel(pix_word));
      // compare each result word with the oldest prediction
      if (res_valid && res_ready) begin
        if (shaded_q.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("%0t: result word with nothing pending: index %0d word %08h",
                     $time, res_word.pixel_index, res_word.pixel_word);
        end else begin
          want = shaded_q.pop_front();
          if (res_word.pixel_index !== want.pixel_index ||
              res_word.pixel_word !== want.pixel_word) begin
            miss_count++;
            if (miss_count <= 10)
              $display("%0t: bad result: index exp %0d got %0d, word exp %08h got %08h",
                       $time, want.pixel_index, res_word.pixel_index,
                       want.pixel_word, res_word.pixel_word);
          end
        end
      end
    end
    bad_words     <= miss_count;
    pending_words <= shaded_q.size();
  end

endmodule

/* sim/hashed_pixel_noise_shader_tb.sv */
module hashed_pixel_noise_shader_tb import hpns_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_PIXELS   = 105;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_ready;
  pix_word_t             pix_word = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  res_word_t             res_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int bad_words;
  int pending_words;
  int burst_left;
  int pixels_sent;
  int settings_used;
  int idle_cycles;
  int ready_mode;
  int ready_left;

  hashed_pixel_noise_shader uut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_word  (pix_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hpns_shade_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .pix_word      (pix_word),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_word      (res_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .bad_words     (bad_words),
    .pending_words (pending_words)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: stretches of always-ready, coin-flip, mostly-stalled, fully stalled
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(5, 60);
    end else begin
      ready_left = ready_left - 1;
    end
    case (ready_mode)
      0:       res_ready <= 1'b1;
      1:       res_ready <= 1'($urandom_range(0, 1));
      2:       res_ready <= ($urandom_range(0, 7) == 0);
      default: res_ready <= 1'b0;
    endcase
  end

  // Watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired at %0t", $time);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pix_word_t make_pixel(logic [3:0] trow, logic [3:0] tcol,
                                           logic [2:0] srow, logic [2:0] scol,
                                           logic [7:0] red, logic [7:0] green,
                                           logic [7:0] blue);
    return '{trow, tcol, srow, scol, red, green, blue};
  endfunction

  // Channel levels weighted toward both ends so saturation gets hit
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 15));
      1:       return 8'($urandom_range(240, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_chunk();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one pixel word, opening a new burst after a random gap when needed
  task automatic push_pixel(input pix_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pix_word  <= w;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    burst_left = burst_left - 1;
    pixels_sent++;
  endtask

  task automatic push_random(input int count);
    repeat (count)
      push_pixel(make_pixel(4'($urandom), 4'($urandom), 3'($urandom), 3'($urandom),
                            pick_level(), pick_level(), pick_level()));
  endtask

  // Stop sending and wait until every predicted word has come back
  task automatic settle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all three registers, optionally poking the unused index too
  task automatic load_regs(input logic [15:0] cx, input logic [15:0] cy,
                           input logic [15:0] amp_data, input bit poke_spare);
    cfg_put(REG_CHUNK_X, cx);
    cfg_put(REG_CHUNK_Y, cy);
    cfg_put(REG_NOISE_AMP, amp_data);
    if (poke_spare) cfg_put(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [6:0] amp7;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // Reset values: chunk 0,0 and amplitude 8
    push_pixel(make_pixel(4'd0, 4'd0, 3'd0, 3'd0, 8'd0, 8'd0, 8'd0));
    push_pixel(make_pixel(4'd15, 4'd15, 3'd7, 3'd7, 8'd255, 8'd255, 8'd255));
    push_pixel(make_pixel(4'd0, 4'd15, 3'd0, 3'd7, 8'd0, 8'd128, 8'd255));
    push_pixel(make_pixel(4'd15, 4'd0, 3'd7, 3'd0, 8'd255, 8'd0, 8'd8));
    push_pixel(make_pixel(4'd5, 4'd10, 3'd3, 3'd4, 8'd4, 8'd251, 8'd100));
    push_pixel(make_pixel(4'd8, 4'd8, 3'd4, 3'd4, 8'd7, 8'd248, 8'd127));
    settle();

    // Full amplitude at the far chunk corner; spare index must not disturb anything
    load_regs(16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
    push_pixel(make_pixel(4'd0, 4'd0, 3'd0, 3'd0, 8'd0, 8'd255, 8'd128));
    push_pixel(make_pixel(4'd15, 4'd15, 3'd7, 3'd7, 8'd255, 8'd0, 8'd1));
    push_pixel(make_pixel(4'd0, 4'd15, 3'd7, 3'd0, 8'd127, 8'd128, 8'd64));
    push_pixel(make_pixel(4'd15, 4'd0, 3'd0, 3'd7, 8'd1, 8'd254, 8'd200));
    settle();

    // Zero amplitude with upper data bits set: colors pass straight through
    load_regs(16'h8000, 16'h7FFF, 16'hFF80, 1'b0);
    push_pixel(make_pixel(4'd0, 4'd0, 3'd0, 3'd0, 8'd0, 8'd255, 8'd77));
    push_pixel(make_pixel(4'd15, 4'd15, 3'd7, 3'd7, 8'd255, 8'd0, 8'd170));
    push_pixel(make_pixel(4'd9, 4'd6, 3'd2, 3'd5, 8'd85, 8'd1, 8'd254));
    settle();

    // Smallest nonzero amplitude around the origin
    load_regs(16'hFFFF, 16'h0001, 16'h0001, 1'b1);
    push_pixel(make_pixel(4'd0, 4'd0, 3'd0, 3'd0, 8'd0, 8'd255, 8'd1));
    push_pixel(make_pixel(4'd15, 4'd15, 3'd7, 3'd7, 8'd254, 8'd0, 8'd255));
    push_pixel(make_pixel(4'd3, 4'd12, 3'd6, 3'd1, 8'd0, 8'd255, 8'd128));
    settle();

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       amp7 = 7'd0;
        1:       amp7 = 7'd127;
        2:       amp7 = 7'($urandom_range(1, 16));
        default: amp7 = 7'($urandom);
      endcase
      load_regs(pick_chunk(), pick_chunk(), {9'($urandom), amp7},
                1'($urandom_range(0, 1)));
      push_random(PHASE_PIXELS);
      settle();
    end

    repeat (20) @(posedge clk);
    $display("Shaded %0d pixel words under %0d register settings,", pixels_sent,
             settings_used);
    $display("zero and full amplitude, chunk corners and saturation at both ends.");
    if (bad_words == 0 && pending_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
